FILE: rtl/core/ptd_pkg.sv
// Package for the periodic task dispatcher: codes, default sizes, and the
// command and status bundles between controller and datapath.
// No dependencies; compile first.
package ptd_pkg;

  // default sizes handed to the top level parameters
  localparam int SLOTS_DEF     = 16;
  localparam int TIME_BITS_DEF = 32;

  // fixed field widths of the transactions
  localparam int SLOT_FIELD_W = 4;
  localparam int NUM_W        = 32;
  localparam int INTERVAL_W   = 32;

  typedef enum logic [1:0] {
    ACT_CREATE = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_ENABLE = 2'd2,
    ACT_RUN    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_CREATE   = 2'd0,
    KIND_DELETE   = 2'd1,
    KIND_ENABLE   = 2'd2,
    KIND_DISPATCH = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STS_OK          = 2'd0,
    STS_FULL        = 2'd1,
    STS_BAD_SLOT    = 2'd2,
    STS_NOTHING_DUE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_FIND,
    S_NUM_RD,
    S_NUM_WT,
    S_DEL_RD,
    S_DEL_WR,
    S_RUN_RD,
    S_RUN_SL,
    S_RUN_EL,
    S_RUN_CMP,
    S_ACK
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;    // capture the input transaction
    logic set_res;      // preset the result for the action
    logic find_take;    // claim the free slot at the scan index
    logic step_idx;     // advance the scan index
    logic rd_number;    // read the id of the addressed slot
    logic take_number;  // copy that id into the result
    logic set_enable;   // write the enable flag of the addressed slot
    logic clear_entry;  // drop the addressed slot
    logic rd_order;     // read the creation order at the scan index
    logic compact_step; // keep the order entry unless it is the deleted slot
    logic set_count_w;  // task count takes the compacted length
    logic rd_entry;     // read interval, last run and id of the ordered slot
    logic latch_entry;  // register elapsed time and eligibility
    logic dispatch;     // record a due task
    logic emit_final;   // load the output with the last result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    action_t action;
    logic    full;
    logic    bad;
    logic    empty;
    logic    slot_free;
    logic    scan_done;
    logic    due;
    logic    hit;
    logic    out_busy;
  } sts_t;

endpackage

FILE: rtl/core/ptd_if.sv
// Handshake channels of the periodic task dispatcher: item in, result out.
// Field widths are fixed; no package dependency.
interface ptd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [3:0]  slot;
  logic [31:0] interval_ms;
  logic        enable_value;
  logic [31:0] now_ms;

  modport source(output valid, action, slot, interval_ms, enable_value, now_ms,
                 input ready);
  modport sink(input valid, action, slot, interval_ms, enable_value, now_ms,
               output ready);
endinterface

interface ptd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [1:0]  status;
  logic [3:0]  task_slot;
  logic [31:0] task_number;
  logic        last;

  modport source(output valid, kind, status, task_slot, task_number, last,
                 input ready);
  modport sink(input valid, kind, status, task_slot, task_number, last,
               output ready);
endinterface

FILE: rtl/core/periodic_task_dispatcher_unit.sv
// Periodic task dispatcher, top level. Takes one transaction at a time:
// in_ch.ready is high only while the controller is idle. A create walks the
// occupied slots below the free one it claims; a delete compacts the
// creation-order RAM, reading each entry and writing back those it keeps; a
// run on a non-empty table reads the order RAM and the entry RAMs and does the
// registered elapsed-time compare for each task, waiting while the sink holds
// off a result. Bad slot, full table and runs on an empty table go straight
// to the ack. Results wait in an output register while the next transaction
// is taken. No clearing pass after reset.
// Depends on ptd_pkg, ptd_if, ptd_ctrl and ptd_dp.
module periodic_task_dispatcher_unit #(
  parameter int SLOTS     = ptd_pkg::SLOTS_DEF,
  parameter int TIME_BITS = ptd_pkg::TIME_BITS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  ptd_in_if.sink   in_ch,
  ptd_out_if.source out_ch
);

  ptd_pkg::cmd_t cmd;
  ptd_pkg::sts_t sts;

  // sequencer
  ptd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // table and result path
  ptd_dp #(.SLOTS(SLOTS), .TIME_BITS(TIME_BITS)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_action       (in_ch.action),
    .in_slot         (in_ch.slot),
    .in_interval_ms  (in_ch.interval_ms),
    .in_enable_value (in_ch.enable_value),
    .in_now_ms       (in_ch.now_ms),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_kind        (out_ch.kind),
    .out_status      (out_ch.status),
    .out_task_slot   (out_ch.task_slot),
    .out_task_number (out_ch.task_number),
    .out_last        (out_ch.last)
  );

endmodule

FILE: rtl/core/ptd_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered, enabled read data. No dependencies.
module ptd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/ptd_dp.sv
// Datapath of the periodic task dispatcher: task table, creation order,
// scan counters, result staging and output register.
// Depends on ptd_pkg and ptd_ram.
module ptd_dp #(
  parameter int SLOTS     = ptd_pkg::SLOTS_DEF,
  parameter int TIME_BITS = ptd_pkg::TIME_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ptd_pkg::cmd_t                     cmd,
  output ptd_pkg::sts_t                     sts,
  input  logic [1:0]                        in_action,
  input  logic [ptd_pkg::SLOT_FIELD_W-1:0]  in_slot,
  input  logic [ptd_pkg::INTERVAL_W-1:0]    in_interval_ms,
  input  logic                              in_enable_value,
  input  logic [31:0]                       in_now_ms,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_kind,
  output logic [1:0]                        out_status,
  output logic [ptd_pkg::SLOT_FIELD_W-1:0]  out_task_slot,
  output logic [ptd_pkg::NUM_W-1:0]         out_task_number,
  output logic                              out_last
);

  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW    = $clog2(SLOTS + 1);
  localparam int CMP_W = (TIME_BITS > ptd_pkg::INTERVAL_W) ? TIME_BITS
                                                           : ptd_pkg::INTERVAL_W;

  // captured transaction
  ptd_pkg::action_t                 action_r;
  logic [ptd_pkg::SLOT_FIELD_W-1:0] slot_r;
  logic [ptd_pkg::INTERVAL_W-1:0]   interval_r;
  logic                             en_r;
  logic [TIME_BITS-1:0]             now_r;

  // table control state
  logic [SLOTS-1:0]          valid_r;
  logic [SLOTS-1:0]          enable_r;
  logic [CW-1:0]             count_r;
  logic [ptd_pkg::NUM_W-1:0] next_num_r;

  // scan state
  logic [CW-1:0]        idx_r;
  logic [CW-1:0]        wptr_r;
  logic [SW-1:0]        sel_r;
  logic                 elig_r;
  logic [TIME_BITS-1:0] elapsed_r;

  // result staging
  ptd_pkg::kind_t                   res_kind_r;
  ptd_pkg::status_t                 res_status_r;
  logic [ptd_pkg::SLOT_FIELD_W-1:0] res_slot_r;
  logic [ptd_pkg::NUM_W-1:0]        res_number_r;
  logic                             hit_r;

  // output register
  logic                             out_valid_r;
  ptd_pkg::kind_t                   out_kind_r;
  ptd_pkg::status_t                 out_status_r;
  logic [ptd_pkg::SLOT_FIELD_W-1:0] out_slot_r;
  logic [ptd_pkg::NUM_W-1:0]        out_number_r;
  logic                             out_last_r;

  // memory ports
  logic [SW-1:0]                  ord_rdata;
  logic                           ord_we;
  logic [SW-1:0]                  ord_waddr;
  logic [SW-1:0]                  ord_wdata;
  logic [ptd_pkg::INTERVAL_W-1:0] int_rdata;
  logic [TIME_BITS-1:0]           last_rdata;
  logic                           last_we;
  logic [SW-1:0]                  last_waddr;
  logic [ptd_pkg::NUM_W-1:0]      num_rdata;
  logic [SW-1:0]                  num_raddr;

  logic [SW-1:0] slot_idx;
  logic [SW-1:0] scan_idx;
  logic          slot_in_range;
  logic          load_out;

  assign slot_idx      = SW'(slot_r);
  assign scan_idx      = idx_r[SW-1:0];
  assign slot_in_range = {28'd0, slot_r} < 32'(SLOTS);
  assign load_out      = cmd.emit_final || (cmd.dispatch && hit_r);

  // status toward the controller
  assign sts.action    = action_r;
  assign sts.full      = (count_r == CW'(SLOTS));
  assign sts.bad       = !slot_in_range || !valid_r[slot_idx];
  assign sts.empty     = (count_r == '0);
  assign sts.slot_free = !valid_r[scan_idx];
  assign sts.scan_done = (idx_r == count_r);
  assign sts.due       = elig_r && (CMP_W'(elapsed_r) >= CMP_W'(int_rdata));
  assign sts.hit       = hit_r;
  assign sts.out_busy  = out_valid_r && !out_ready;

  // creation order: appended on create, compacted on delete
  always_comb begin
    ord_we    = 1'b0;
    ord_waddr = count_r[SW-1:0];
    ord_wdata = scan_idx;
    if (cmd.find_take) begin
      ord_we = 1'b1;
    end else if (cmd.compact_step && (ord_rdata != slot_idx)) begin
      ord_we    = 1'b1;
      ord_waddr = wptr_r[SW-1:0];
      ord_wdata = ord_rdata;
    end
  end

  ptd_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_order_ram (
    .clk   (clk),
    .we    (ord_we),
    .waddr (ord_waddr),
    .wdata (ord_wdata),
    .re    (cmd.rd_order),
    .raddr (scan_idx),
    .rdata (ord_rdata)
  );

  ptd_ram #(.WIDTH(ptd_pkg::INTERVAL_W), .DEPTH(SLOTS)) u_interval_ram (
    .clk   (clk),
    .we    (cmd.find_take),
    .waddr (scan_idx),
    .wdata (interval_r),
    .re    (cmd.rd_entry),
    .raddr (ord_rdata),
    .rdata (int_rdata)
  );

  // last run is written on create and on every dispatch
  assign last_we    = cmd.find_take || cmd.dispatch;
  assign last_waddr = cmd.dispatch ? sel_r : scan_idx;

  ptd_ram #(.WIDTH(TIME_BITS), .DEPTH(SLOTS)) u_last_ram (
    .clk   (clk),
    .we    (last_we),
    .waddr (last_waddr),
    .wdata (now_r),
    .re    (cmd.rd_entry),
    .raddr (ord_rdata),
    .rdata (last_rdata)
  );

  assign num_raddr = cmd.rd_number ? slot_idx : ord_rdata;

  ptd_ram #(.WIDTH(ptd_pkg::NUM_W), .DEPTH(SLOTS)) u_number_ram (
    .clk   (clk),
    .we    (cmd.find_take),
    .waddr (scan_idx),
    .wdata (next_num_r),
    .re    (cmd.rd_number || cmd.rd_entry),
    .raddr (num_raddr),
    .rdata (num_rdata)
  );

  // control state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      enable_r    <= '0;
      count_r     <= '0;
      next_num_r  <= 32'd1;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.find_take) begin
        valid_r[scan_idx]  <= 1'b1;
        enable_r[scan_idx] <= 1'b1;
        count_r            <= count_r + CW'(1);
        next_num_r         <= next_num_r + 32'd1;
      end
      if (cmd.set_enable) begin
        enable_r[slot_idx] <= en_r;
      end
      if (cmd.clear_entry) begin
        valid_r[slot_idx]  <= 1'b0;
        enable_r[slot_idx] <= 1'b0;
      end
      if (cmd.set_count_w) begin
        count_r <= wptr_r;
      end
      if (cmd.set_res) begin
        hit_r <= 1'b0;
      end else if (cmd.dispatch) begin
        hit_r <= 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // capture, scan counters and elapsed time
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      action_r   <= ptd_pkg::action_t'(in_action);
      slot_r     <= in_slot;
      interval_r <= in_interval_ms;
      en_r       <= in_enable_value;
      now_r      <= TIME_BITS'(in_now_ms);
      idx_r      <= '0;
      wptr_r     <= '0;
    end else begin
      if (cmd.step_idx) begin
        idx_r <= idx_r + CW'(1);
      end
      if (cmd.compact_step && (ord_rdata != slot_idx)) begin
        wptr_r <= wptr_r + CW'(1);
      end
    end
    if (cmd.rd_entry) begin
      sel_r <= ord_rdata;
    end
    if (cmd.latch_entry) begin
      elapsed_r <= now_r - last_rdata;
      elig_r    <= valid_r[sel_r] && enable_r[sel_r];
    end
  end

  // result staging
  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      res_slot_r   <= '0;
      res_number_r <= '0;
      case (action_r)
        ptd_pkg::ACT_CREATE: begin
          res_kind_r   <= ptd_pkg::KIND_CREATE;
          res_status_r <= sts.full ? ptd_pkg::STS_FULL : ptd_pkg::STS_OK;
        end
        ptd_pkg::ACT_DELETE: begin
          res_kind_r   <= ptd_pkg::KIND_DELETE;
          res_status_r <= sts.bad ? ptd_pkg::STS_BAD_SLOT : ptd_pkg::STS_OK;
          res_slot_r   <= slot_r;
        end
        ptd_pkg::ACT_ENABLE: begin
          res_kind_r   <= ptd_pkg::KIND_ENABLE;
          res_status_r <= sts.bad ? ptd_pkg::STS_BAD_SLOT : ptd_pkg::STS_OK;
          res_slot_r   <= slot_r;
        end
        default: begin
          res_kind_r   <= ptd_pkg::KIND_DISPATCH;
          res_status_r <= ptd_pkg::STS_NOTHING_DUE;
        end
      endcase
    end else if (cmd.find_take) begin
      res_slot_r   <= ptd_pkg::SLOT_FIELD_W'(scan_idx);
      res_number_r <= next_num_r;
    end else if (cmd.take_number) begin
      res_number_r <= num_rdata;
    end else if (cmd.dispatch) begin
      res_kind_r   <= ptd_pkg::KIND_DISPATCH;
      res_status_r <= ptd_pkg::STS_OK;
      res_slot_r   <= ptd_pkg::SLOT_FIELD_W'(sel_r);
      res_number_r <= num_rdata;
    end
  end

  // output payload: a dispatch pushes the previous one out with last low
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_kind_r   <= res_kind_r;
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      out_number_r <= res_number_r;
      out_last_r   <= cmd.emit_final;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_status      = out_status_r;
  assign out_task_slot   = out_slot_r;
  assign out_task_number = out_number_r;
  assign out_last        = out_last_r;

endmodule

FILE: rtl/core/ptd_ctrl.sv
// Controller of the periodic task dispatcher: sequences each action through
// the datapath. Depends on ptd_pkg.
module ptd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ptd_pkg::sts_t sts,
  output ptd_pkg::cmd_t cmd
);

  ptd_pkg::state_t state_r;
  ptd_pkg::state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ptd_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ptd_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ptd_pkg::S_DECODE;
        end
      end
      ptd_pkg::S_DECODE: begin
        cmd.set_res = 1'b1;
        unique case (sts.action) inside
          ptd_pkg::ACT_CREATE: begin
            state_nxt = sts.full ? ptd_pkg::S_ACK : ptd_pkg::S_FIND;
          end
          ptd_pkg::ACT_DELETE, ptd_pkg::ACT_ENABLE: begin
            state_nxt = sts.bad ? ptd_pkg::S_ACK : ptd_pkg::S_NUM_RD;
          end
          default: begin
            state_nxt = sts.empty ? ptd_pkg::S_ACK : ptd_pkg::S_RUN_RD;
          end
        endcase
      end
      // walk the valid bits for the lowest free slot
      ptd_pkg::S_FIND: begin
        if (sts.slot_free) begin
          cmd.find_take = 1'b1;
          state_nxt     = ptd_pkg::S_ACK;
        end else begin
          cmd.step_idx = 1'b1;
        end
      end
      ptd_pkg::S_NUM_RD: begin
        cmd.rd_number = 1'b1;
        state_nxt     = ptd_pkg::S_NUM_WT;
      end
      ptd_pkg::S_NUM_WT: begin
        cmd.take_number = 1'b1;
        if (sts.action == ptd_pkg::ACT_ENABLE) begin
          cmd.set_enable = 1'b1;
          state_nxt      = ptd_pkg::S_ACK;
        end else begin
          cmd.clear_entry = 1'b1;
          state_nxt       = ptd_pkg::S_DEL_RD;
        end
      end
      // compact the creation order around the deleted slot
      ptd_pkg::S_DEL_RD: begin
        if (sts.scan_done) begin
          cmd.set_count_w = 1'b1;
          state_nxt       = ptd_pkg::S_ACK;
        end else begin
          cmd.rd_order = 1'b1;
          state_nxt    = ptd_pkg::S_DEL_WR;
        end
      end
      ptd_pkg::S_DEL_WR: begin
        cmd.compact_step = 1'b1;
        cmd.step_idx     = 1'b1;
        state_nxt        = ptd_pkg::S_DEL_RD;
      end
      // run: one task per pass, in creation order
      ptd_pkg::S_RUN_RD: begin
        if (sts.scan_done) begin
          state_nxt = ptd_pkg::S_ACK;
        end else begin
          cmd.rd_order = 1'b1;
          state_nxt    = ptd_pkg::S_RUN_SL;
        end
      end
      ptd_pkg::S_RUN_SL: begin
        cmd.rd_entry = 1'b1;
        state_nxt    = ptd_pkg::S_RUN_EL;
      end
      ptd_pkg::S_RUN_EL: begin
        cmd.latch_entry = 1'b1;
        state_nxt       = ptd_pkg::S_RUN_CMP;
      end
      ptd_pkg::S_RUN_CMP: begin
        if (!sts.due) begin
          cmd.step_idx = 1'b1;
          state_nxt    = ptd_pkg::S_RUN_RD;
        end else if (!(sts.hit && sts.out_busy)) begin
          cmd.dispatch = 1'b1;
          cmd.step_idx = 1'b1;
          state_nxt    = ptd_pkg::S_RUN_RD;
        end
      end
      ptd_pkg::S_ACK: begin
        if (!sts.out_busy) begin
          cmd.emit_final = 1'b1;
          state_nxt      = ptd_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ptd_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/ptd_checker.sv
// Port-level checks for the periodic task dispatcher, bound to the top level.
// Depends on ptd_pkg and periodic_task_dispatcher_unit.
module ptd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [1:0]  out_status,
  input logic [3:0]  out_task_slot,
  input logic [31:0] out_task_number,
  input logic        out_last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_status)
      && $stable(out_task_slot) && $stable(out_task_number) && $stable(out_last))
    else $error("stalled result changed");

  // one transaction at a time: busy right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a transaction is in progress");

  // acks are single results
  a_ack_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != ptd_pkg::KIND_DISPATCH) |-> out_last)
    else $error("ack without last");

  // nothing due is a lone, empty dispatch result
  a_nothing_due: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ptd_pkg::STS_NOTHING_DUE) |->
      (out_kind == ptd_pkg::KIND_DISPATCH) && out_last && (out_task_slot == 4'd0)
      && (out_task_number == 32'd0))
    else $error("malformed nothing-due result");

  // a full table gives an empty create ack
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ptd_pkg::STS_FULL) |->
      (out_kind == ptd_pkg::KIND_CREATE) && (out_task_slot == 4'd0)
      && (out_task_number == 32'd0))
    else $error("malformed table-full result");

endmodule

bind periodic_task_dispatcher_unit ptd_checker u_ptd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_kind        (out_ch.kind),
  .out_status      (out_ch.status),
  .out_task_slot   (out_ch.task_slot),
  .out_task_number (out_ch.task_number),
  .out_last        (out_ch.last)
);

FILE: tb/ptd_dispatch_checker.sv
`timescale 1ns / 1ps
// Checker for the periodic task dispatcher: watches the command and result channels,
// keeps a shadow task table and compares every result transaction in order.
// Depends on ptd_pkg and the ptd_in_if / ptd_out_if channel interfaces.
module ptd_dispatch_checker (
  input  logic        clk,
  input  logic        rst_n,
  ptd_in_if           cmd_mon,
  ptd_out_if          res_mon,
  output int          mismatches,
  output int          owed_count,
  output logic [15:0] busy_slots,
  output int          live_tasks,
  output int          n_commands,
  output int          n_results,
  output int          n_dispatched,
  output int          n_full,
  output int          n_bad_slot
);

  localparam int SLOTS_N = ptd_pkg::SLOTS_DEF;

  typedef struct packed {
    ptd_pkg::kind_t   kind;
    ptd_pkg::status_t status;
    logic [3:0]       task_slot;
    logic [31:0]      task_number;
    logic             last;
  } ack_rec_t;

  // results owed by the block, oldest first
  ack_rec_t owed_acks[$];

  // shadow task table
  logic [SLOTS_N-1:0] slot_used;
  logic [SLOTS_N-1:0] slot_on;
  logic [31:0]        period_ms[SLOTS_N];
  logic [31:0]        ran_at_ms[SLOTS_N];
  logic [31:0]        task_id[SLOTS_N];
  logic [3:0]         creation_order[SLOTS_N];
  int                 order_len;
  logic [31:0]        id_counter;

  function automatic void clear_table();
    slot_used  = '0;
    slot_on    = '0;
    order_len  = 0;
    id_counter = 32'd1;
    owed_acks.delete();
  endfunction

  function automatic void owe(ptd_pkg::kind_t k, ptd_pkg::status_t s, logic [3:0] sl,
                              logic [31:0] num);
    ack_rec_t rec;
    rec.kind        = k;
    rec.status      = s;
    rec.task_slot   = sl;
    rec.task_number = num;
    rec.last        = 1'b1;
    owed_acks.push_back(rec);
  endfunction

  // work out the results of one command transaction and update the table
  function automatic void apply_command(ptd_pkg::action_t act, logic [3:0] sel,
                                        logic [31:0] ivl, logic en, logic [31:0] now);
    int             free_slot;
    int             i;
    int             w;
    int             hits;
    logic [3:0]     s;
    logic [31:0]    elapsed;
    ptd_pkg::kind_t k;
    ack_rec_t       held;
    n_commands++;
    free_slot = -1;
    hits      = 0;
    held      = '0;
    case (act)
      ptd_pkg::ACT_CREATE: begin
        if (order_len < SLOTS_N) begin
          for (i = SLOTS_N - 1; i >= 0; i--)
            if (!slot_used[i]) free_slot = i;
        end
        if (free_slot < 0) begin
          owe(ptd_pkg::KIND_CREATE, ptd_pkg::STS_FULL, 4'd0, 32'd0);
          n_full++;
        end else begin
          slot_used[free_slot]       = 1'b1;
          slot_on[free_slot]         = 1'b1;
          period_ms[free_slot]       = ivl;
          ran_at_ms[free_slot]       = now;
          task_id[free_slot]         = id_counter;
          creation_order[order_len]  = 4'(free_slot);
          order_len++;
          owe(ptd_pkg::KIND_CREATE, ptd_pkg::STS_OK, 4'(free_slot), id_counter);
          id_counter = id_counter + 32'd1;
        end
      end
      ptd_pkg::ACT_DELETE, ptd_pkg::ACT_ENABLE: begin
        if (act == ptd_pkg::ACT_DELETE) k = ptd_pkg::KIND_DELETE;
        else k = ptd_pkg::KIND_ENABLE;
        if (int'(sel) >= SLOTS_N || !slot_used[sel]) begin
          owe(k, ptd_pkg::STS_BAD_SLOT, sel, 32'd0);
          n_bad_slot++;
        end else begin
          if (act == ptd_pkg::ACT_ENABLE) begin
            slot_on[sel] = en;
          end else begin
            // drop the slot from the creation order, keeping the rest in sequence
            w = 0;
            for (i = 0; i < order_len; i++) begin
              if (creation_order[i] != sel) begin
                creation_order[w] = creation_order[i];
                w++;
              end
            end
            order_len      = w;
            slot_used[sel] = 1'b0;
            slot_on[sel]   = 1'b0;
          end
          owe(k, ptd_pkg::STS_OK, sel, task_id[sel]);
        end
      end
      default: begin
        // run: visit tasks in creation order, emit each one that is due
        for (i = 0; i < order_len; i++) begin
          s = creation_order[i];
          if (slot_used[s] && slot_on[s]) begin
            elapsed = now - ran_at_ms[s];
            if (elapsed >= period_ms[s]) begin
              ran_at_ms[s] = now;
              if (hits > 0) owed_acks.push_back(held);
              held.kind        = ptd_pkg::KIND_DISPATCH;
              held.status      = ptd_pkg::STS_OK;
              held.task_slot   = s;
              held.task_number = task_id[s];
              held.last        = 1'b0;
              hits++;
            end
          end
        end
        if (hits == 0) begin
          owe(ptd_pkg::KIND_DISPATCH, ptd_pkg::STS_NOTHING_DUE, 4'd0, 32'd0);
        end else begin
          held.last = 1'b1;
          owed_acks.push_back(held);
          n_dispatched += hits;
        end
      end
    endcase
  endfunction

  // compare one result transaction with the oldest owed one
  function automatic void check_result();
    ack_rec_t want;
    n_results++;
    if (owed_acks.size() == 0) begin
      $error("unexpected result: kind %0d status %0d slot %0d number %0d",
             res_mon.kind, res_mon.status, res_mon.task_slot, res_mon.task_number);
      mismatches++;
      return;
    end
    want = owed_acks.pop_front();
    if (res_mon.kind !== want.kind) begin
      $error("kind mismatch: expected %0d, got %0d", want.kind, res_mon.kind);
      mismatches++;
    end
    if (res_mon.status !== want.status) begin
      $error("status mismatch: expected %0d, got %0d", want.status, res_mon.status);
      mismatches++;
    end
    if (res_mon.task_slot !== want.task_slot) begin
      $error("task_slot mismatch: expected %0d, got %0d", want.task_slot, res_mon.task_slot);
      mismatches++;
    end
    if (res_mon.task_number !== want.task_number) begin
      $error("task_number mismatch: expected %0d, got %0d",
             want.task_number, res_mon.task_number);
      mismatches++;
    end
    if (res_mon.last !== want.last) begin
      $error("last mismatch: expected %0d, got %0d", want.last, res_mon.last);
      mismatches++;
    end
  endfunction

  // results first: they always belong to commands taken earlier
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_table();
    end else begin
      if (res_mon.valid === 1'b1 && res_mon.ready === 1'b1) check_result();
      if (cmd_mon.valid === 1'b1 && cmd_mon.ready === 1'b1)
        apply_command(ptd_pkg::action_t'(cmd_mon.action), cmd_mon.slot,
                      cmd_mon.interval_ms, cmd_mon.enable_value, cmd_mon.now_ms);
    end
    owed_count = owed_acks.size();
    busy_slots = 16'(slot_used);
    live_tasks = order_len;
  end

endmodule

FILE: tb/tb_periodic_task_dispatcher_unit.sv
`timescale 1ns / 1ps
// Testbench top for the periodic task dispatcher: drives directed and random
// commands with random idling on both channels and reports the verdict.
// Depends on ptd_pkg, ptd_if, the dispatcher RTL and ptd_dispatch_checker.
module tb_periodic_task_dispatcher_unit;

  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 120;

  logic        clk;
  logic        rst_n;
  int          send_gap_pct;
  int          stall_pct;
  int          quiet_cycles;
  int          mismatches;
  int          owed_count;
  int          live_tasks;
  int          n_commands;
  int          n_results;
  int          n_dispatched;
  int          n_full;
  int          n_bad_slot;
  logic [15:0] busy_slots;

  ptd_in_if  in_ch();
  ptd_out_if out_ch();

  periodic_task_dispatcher_unit DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  ptd_dispatch_checker dispatch_watch (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_mon     (in_ch),
    .res_mon     (out_ch),
    .mismatches  (mismatches),
    .owed_count  (owed_count),
    .busy_slots  (busy_slots),
    .live_tasks  (live_tasks),
    .n_commands  (n_commands),
    .n_results   (n_results),
    .n_dispatched(n_dispatched),
    .n_full      (n_full),
    .n_bad_slot  (n_bad_slot)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // idle stretch length: mostly short, now and then long
  function automatic int idle_len();
    if ($urandom_range(9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // one command transaction; entered and left at a falling edge
  task automatic send_cmd(input ptd_pkg::action_t act, input logic [3:0] sel,
                          input logic [31:0] ivl, input logic en, input logic [31:0] now);
    int gap;
    gap = ($urandom_range(99) < send_gap_pct) ? idle_len() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.action       <= act;
    in_ch.slot         <= sel;
    in_ch.interval_ms  <= ivl;
    in_ch.enable_value <= en;
    in_ch.now_ms       <= now;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    @(negedge clk);
  endtask

  // result side back-pressure
  initial begin : result_sink
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else if ($urandom_range(99) < stall_pct) begin
        hold = idle_len() - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("tb_periodic_task_dispatcher_unit failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus
  initial begin : stimulus
    int               k;
    int               phase;
    int               roll;
    int               create_w;
    logic [31:0]      clock_ms;
    logic [31:0]      ivl;
    logic [31:0]      now;
    logic [3:0]       sel;
    ptd_pkg::action_t act;

    in_ch.valid        = 1'b0;
    in_ch.action       = ptd_pkg::ACT_RUN;
    in_ch.slot         = 4'd0;
    in_ch.interval_ms  = 32'd0;
    in_ch.enable_value = 1'b0;
    in_ch.now_ms       = 32'd0;
    send_gap_pct       = 20;
    stall_pct          = 20;
    rst_n              = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty table, bad slots, interval extremes, wrap of time
    send_cmd(ptd_pkg::ACT_RUN,    4'd0,  32'd0,         1'b0, 32'd0);
    send_cmd(ptd_pkg::ACT_DELETE, 4'd5,  32'd0,         1'b0, 32'd0);
    send_cmd(ptd_pkg::ACT_ENABLE, 4'd15, 32'd0,         1'b1, 32'd0);
    send_cmd(ptd_pkg::ACT_CREATE, 4'd0,  32'd0,         1'b0, 32'hFFFF_FFF0);
    send_cmd(ptd_pkg::ACT_CREATE, 4'd0,  32'hFFFF_FFFF, 1'b0, 32'd0);
    send_cmd(ptd_pkg::ACT_CREATE, 4'd0,  32'd100,       1'b0, 32'hFFFF_FFC0);
    send_cmd(ptd_pkg::ACT_RUN,    4'd0,  32'd0,         1'b0, 32'h0000_0024);
    send_cmd(ptd_pkg::ACT_ENABLE, 4'd0,  32'd0,         1'b0, 32'd0);
    send_cmd(ptd_pkg::ACT_RUN,    4'd0,  32'd0,         1'b0, 32'h0000_0030);
    send_cmd(ptd_pkg::ACT_ENABLE, 4'd0,  32'd0,         1'b1, 32'd0);
    // fill the table, hit the full case, reuse a freed slot
    for (k = 0; k < 13; k++)
      send_cmd(ptd_pkg::ACT_CREATE, 4'd0, 32'($urandom_range(50)), 1'b0, 32'd100);
    send_cmd(ptd_pkg::ACT_CREATE, 4'd3, 32'd10, 1'b1, 32'd200);
    send_cmd(ptd_pkg::ACT_DELETE, 4'd7, 32'd0,  1'b0, 32'd0);
    send_cmd(ptd_pkg::ACT_CREATE, 4'd0, 32'd5,  1'b0, 32'd300);
    // every task due at once
    send_cmd(ptd_pkg::ACT_RUN,    4'd0, 32'd0,  1'b0, 32'hFFFF_FFFF);

    // random: quiet channels, then moderate and heavy idling
    clock_ms = 32'hFFFF_F000;
    for (phase = 0; phase < 3; phase++) begin
      send_gap_pct = phase * 30;
      stall_pct    = phase * 25;
      for (k = 0; k < 135; k++) begin
        if (live_tasks < 4) create_w = 50;
        else if (live_tasks == 16) create_w = 10;
        else create_w = 25;
        roll = $urandom_range(99);
        if (roll < create_w) act = ptd_pkg::ACT_CREATE;
        else if (roll < create_w + 15) act = ptd_pkg::ACT_DELETE;
        else if (roll < create_w + 30) act = ptd_pkg::ACT_ENABLE;
        else act = ptd_pkg::ACT_RUN;

        // mostly address a live task, sometimes any slot
        sel = 4'($urandom_range(15));
        if (busy_slots != '0 && $urandom_range(9) != 0)
          while (!busy_slots[sel]) sel = sel + 4'd1;

        roll = $urandom_range(99);
        if (roll < 10) ivl = 32'd0;
        else if (roll < 15) ivl = 32'hFFFF_FFFF;
        else if (roll < 25) ivl = $urandom;
        else ivl = 32'($urandom_range(1, 400));

        // time mostly creeps forward, sometimes jumps anywhere
        roll = $urandom_range(99);
        if (roll < 5) clock_ms = $urandom;
        else if (roll < 90) clock_ms = clock_ms + 32'($urandom_range(150));
        now = (act == ptd_pkg::ACT_CREATE || act == ptd_pkg::ACT_RUN) ? clock_ms : $urandom;

        send_cmd(act, sel, ivl, ($urandom_range(3) != 0), now);
      end
    end
    in_ch.valid <= 1'b0;

    // drain, then spare cycles for stray results
    while (owed_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d commands, %0d results, %0d dispatches", n_commands, n_results,
             n_dispatched);
    $display("including %0d table-full and %0d bad-slot responses", n_full, n_bad_slot);
    if (mismatches == 0 && owed_count == 0) begin
      $display("tb_periodic_task_dispatcher_unit passed");
    end else begin
      $display("tb_periodic_task_dispatcher_unit failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/ptd_pkg.sv
rtl/core/ptd_if.sv
rtl/core/ptd_ram.sv
rtl/core/ptd_dp.sv
rtl/core/ptd_ctrl.sv
rtl/core/periodic_task_dispatcher_unit.sv
rtl/core/ptd_checker.sv
tb/ptd_dispatch_checker.sv
tb/tb_periodic_task_dispatcher_unit.sv
